@@ rtl/rounded_rect_coverage_blend_macros.svh @@
// ---------------------------------------------------------------------------
// Rounded-rect blend assertion macros
// Shared concurrent assertion forms for the blend block.
// ---------------------------------------------------------------------------
`ifndef ROUNDED_RECT_COVERAGE_BLEND_MACROS_SVH
`define ROUNDED_RECT_COVERAGE_BLEND_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RRCB_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrcb assertion failed");

// Next-cycle implication, disabled during reset
`define RRCB_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rrcb assertion failed");

`endif

@@ rtl/rrcb_pkg.sv @@
// ---------------------------------------------------------------------------
// Rounded-rect blend package
// Widths, types, register codes and records shared by the blend modules.
// ---------------------------------------------------------------------------
package rrcb_pkg;

  // Framebuffer limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Field widths
  localparam int CRD_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int SUM_W      = 14;
  localparam int DIST_W     = 13;
  localparam int SQ_W       = 2 * DIST_W;
  localparam int SUMSQ_W    = SQ_W + 1;
  localparam int FRAC_W     = 16;
  localparam int RADICAND_W = SUMSQ_W + FRAC_W;
  localparam int ROOT_W     = (RADICAND_W + 1) / 2;
  localparam int TRIAL_W    = RADICAND_W + 2;
  localparam int SCOV_W     = ROOT_W + 1;
  localparam int COV_W      = 9;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 32;
  localparam int LANES      = PIX_W / CHAN_W;
  localparam int COLOR_W    = 24;
  localparam int PROD_W     = 2 * CHAN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  typedef logic [CRD_W-1:0]             crd_t;
  typedef logic [SIZE_W-1:0]            size_t;
  typedef logic [SUM_W-1:0]             sum_t;
  typedef logic signed [SUM_W:0]        ssum_t;
  typedef logic [DIST_W-1:0]            dist_t;
  typedef logic [SQ_W-1:0]              sq_t;
  typedef logic [SUMSQ_W-1:0]           sumsq_t;
  typedef logic [RADICAND_W-1:0]        radicand_t;
  typedef logic [ROOT_W-1:0]            root_t;
  typedef logic [TRIAL_W-1:0]           trial_t;
  typedef logic signed [SCOV_W-1:0]     scov_t;
  typedef logic [COV_W-1:0]             cov_t;
  typedef logic [CHAN_W-1:0]            chan_t;
  typedef logic [PROD_W-1:0]            prod_t;
  typedef logic [PROD_W:0]              round_t;
  typedef logic [PIX_W-1:0]             pix_t;
  typedef logic [COLOR_W-1:0]           color_t;

  localparam cov_t  COV_ONE  = cov_t'(256);
  localparam chan_t CHAN_MAX = 8'hFF;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_LEFT     = 3'd0,
    CFG_RECT_TOP      = 3'd1,
    CFG_RECT_WIDTH    = 3'd2,
    CFG_RECT_HEIGHT   = 3'd3,
    CFG_CORNER_RADIUS = 3'd4,
    CFG_FILL_COLOR    = 3'd5,
    CFG_FILL_ALPHA    = 3'd6
  } cfg_reg_e;

  // Register file contents
  typedef struct packed {
    crd_t   rect_left;
    crd_t   rect_top;
    size_t  rect_width;
    size_t  rect_height;
    crd_t   corner_radius;
    color_t fill_color;
    chan_t  fill_alpha;
  } cfg_t;

  // Classified pixel carried from front to back
  typedef struct packed {
    logic   in_rect;
    logic   corner;
    sumsq_t dist_sq;
    pix_t   dest;
  } q_item_t;

  // Sideband that rides along the square-root pipeline
  typedef struct packed {
    logic in_rect;
    logic corner;
    pix_t dest;
  } sqrt_side_t;

endpackage

@@ rtl/rrcb_front.sv @@
// ---------------------------------------------------------------------------
// Rounded-rect blend front end
// Accepts pixels, runs the inside test, forms corner distances and squares.
// ---------------------------------------------------------------------------
module rrcb_front (
  input  logic                    clk,
  input  logic                    rst,
  input  rrcb_pkg::cfg_t          cfg,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rrcb_pkg::crd_t          in_x,
  input  rrcb_pkg::crd_t          in_y,
  input  rrcb_pkg::pix_t          in_dest,
  input  logic                    q_full,
  output logic                    q_push,
  output rrcb_pkg::q_item_t       q_item
);

  // Distance past the rounded zone along one axis
  function automatic rrcb_pkg::dist_t edge_dist(
    input rrcb_pkg::crd_t  p,
    input rrcb_pkg::crd_t  lo,
    input rrcb_pkg::size_t span,
    input rrcb_pkg::crd_t  r
  );
    rrcb_pkg::size_t lo_r;
    rrcb_pkg::ssum_t hi;
    rrcb_pkg::ssum_t ps;
    rrcb_pkg::ssum_t diff;
    rrcb_pkg::dist_t res;
    lo_r = rrcb_pkg::size_t'(lo) + rrcb_pkg::size_t'(r);
    hi   = $signed({1'b0, rrcb_pkg::sum_t'(lo) + rrcb_pkg::sum_t'(span)})
         - $signed({3'b000, r});
    ps   = $signed({3'b000, p});
    diff = ps - hi;
    if ({1'b0, p} < lo_r) begin
      res = lo_r - {1'b0, p};
    end else if (ps > hi) begin
      res = diff[rrcb_pkg::DIST_W-1:0];
    end else begin
      res = '0;
    end
    return res;
  endfunction

  logic            adv;
  // stage 1: accepted pixel
  logic            f1_valid;
  rrcb_pkg::crd_t  f1_x;
  rrcb_pkg::crd_t  f1_y;
  rrcb_pkg::pix_t  f1_dest;
  // stage 2: classified
  logic            f2_valid;
  logic            f2_inside;
  logic            f2_corner;
  rrcb_pkg::dist_t f2_dx;
  rrcb_pkg::dist_t f2_dy;
  rrcb_pkg::pix_t  f2_dest;
  // stage 3: squared distances
  logic            f3_valid;
  logic            f3_inside;
  logic            f3_corner;
  rrcb_pkg::sq_t   f3_dx2;
  rrcb_pkg::sq_t   f3_dy2;
  rrcb_pkg::pix_t  f3_dest;

  rrcb_pkg::sum_t  x_end;
  rrcb_pkg::sum_t  y_end;
  logic            in_x_rng;
  logic            in_y_rng;
  rrcb_pkg::dist_t dx;
  rrcb_pkg::dist_t dy;

  // Whole front shifts together; stalls only when the queue cannot take f3
  assign adv      = !f3_valid || !q_full;
  assign in_ready = adv;

  // Inside test and corner distances
  always_comb begin
    x_end    = rrcb_pkg::sum_t'(cfg.rect_left) + rrcb_pkg::sum_t'(cfg.rect_width);
    y_end    = rrcb_pkg::sum_t'(cfg.rect_top) + rrcb_pkg::sum_t'(cfg.rect_height);
    in_x_rng = (f1_x >= cfg.rect_left) && (rrcb_pkg::sum_t'(f1_x) < x_end)
            && (rrcb_pkg::sum_t'(f1_x) < rrcb_pkg::sum_t'(rrcb_pkg::MAX_WIDTH));
    in_y_rng = (f1_y >= cfg.rect_top) && (rrcb_pkg::sum_t'(f1_y) < y_end)
            && (rrcb_pkg::sum_t'(f1_y) < rrcb_pkg::sum_t'(rrcb_pkg::MAX_HEIGHT));
    dx = edge_dist(f1_x, cfg.rect_left, cfg.rect_width, cfg.corner_radius);
    dy = edge_dist(f1_y, cfg.rect_top, cfg.rect_height, cfg.corner_radius);
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
      f3_valid <= 1'b0;
    end else if (adv) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid;
      f3_valid <= f2_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_x      <= in_x;
      f1_y      <= in_y;
      f1_dest   <= in_dest;
      f2_inside <= in_x_rng && in_y_rng;
      f2_corner <= (dx != '0) || (dy != '0);
      f2_dx     <= dx;
      f2_dy     <= dy;
      f2_dest   <= f1_dest;
      f3_inside <= f2_inside;
      f3_corner <= f2_corner;
      f3_dx2    <= rrcb_pkg::sq_t'(f2_dx) * rrcb_pkg::sq_t'(f2_dx);
      f3_dy2    <= rrcb_pkg::sq_t'(f2_dy) * rrcb_pkg::sq_t'(f2_dy);
      f3_dest   <= f2_dest;
    end
  end

  // Queue write
  assign q_push          = f3_valid && adv;
  assign q_item.in_rect  = f3_inside;
  assign q_item.corner   = f3_corner;
  assign q_item.dist_sq  = rrcb_pkg::sumsq_t'(f3_dx2) + rrcb_pkg::sumsq_t'(f3_dy2);
  assign q_item.dest     = f3_dest;

endmodule

@@ rtl/rrcb_queue.sv @@
// ---------------------------------------------------------------------------
// Rounded-rect blend queue
// Small show-ahead FIFO between the front end and the blend back end.
// ---------------------------------------------------------------------------
module rrcb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rrcb_pkg::q_item_t push_item,
  input  logic              pop,
  output rrcb_pkg::q_item_t head,
  output logic              full,
  output logic              empty
);

  rrcb_pkg::q_item_t               mem [rrcb_pkg::Q_DEPTH];
  logic [rrcb_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [rrcb_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [rrcb_pkg::Q_CNT_W-1:0]    count;

  assign full  = (count == rrcb_pkg::Q_CNT_W'(rrcb_pkg::Q_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

@@ rtl/rrcb_isqrt.sv @@
// ---------------------------------------------------------------------------
// Rounded-rect blend square root
// Pipelined restoring integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module rrcb_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  rrcb_pkg::radicand_t  in_radicand,
  input  rrcb_pkg::sqrt_side_t in_side,
  output logic                 out_valid,
  output rrcb_pkg::root_t      out_root,
  output rrcb_pkg::sqrt_side_t out_side
);

  localparam int Stages = rrcb_pkg::ROOT_W;

  logic [Stages-1:0]     vld;
  rrcb_pkg::root_t       root  [Stages];
  rrcb_pkg::radicand_t   rem   [Stages];
  rrcb_pkg::sqrt_side_t  side  [Stages];
  rrcb_pkg::root_t       root_next [Stages];
  rrcb_pkg::radicand_t   rem_next  [Stages];

  // One trial subtraction per stage, most significant root bit first
  always_comb begin
    rrcb_pkg::root_t     src_root;
    rrcb_pkg::radicand_t src_rem;
    rrcb_pkg::trial_t    trial;
    int                  bp;
    for (int k = 0; k < Stages; k++) begin
      bp       = Stages - 1 - k;
      src_root = (k == 0) ? '0 : root[(k == 0) ? 0 : k - 1];
      src_rem  = (k == 0) ? in_radicand : rem[(k == 0) ? 0 : k - 1];
      trial    = (rrcb_pkg::trial_t'(src_root) << (bp + 1))
               + (rrcb_pkg::trial_t'(1) << (2 * bp));
      if (rrcb_pkg::trial_t'(src_rem) >= trial) begin
        rem_next[k]  = src_rem - trial[rrcb_pkg::RADICAND_W-1:0];
        root_next[k] = src_root | (rrcb_pkg::root_t'(1) << bp);
      end else begin
        rem_next[k]  = src_rem;
        root_next[k] = src_root;
      end
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Stages-2:0], in_valid};
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Stages; k++) begin
        root[k] <= root_next[k];
        rem[k]  <= rem_next[k];
        side[k] <= (k == 0) ? in_side : side[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_valid = vld[Stages-1];
  assign out_root  = root[Stages-1];
  assign out_side  = side[Stages-1];

endmodule

@@ rtl/rrcb_back.sv @@
// ---------------------------------------------------------------------------
// Rounded-rect blend back end
// Distance root, corner coverage, effective opacity, channel blend, output.
// ---------------------------------------------------------------------------
module rrcb_back (
  input  logic                clk,
  input  logic                rst,
  input  rrcb_pkg::cfg_t      cfg,
  input  rrcb_pkg::q_item_t   q_head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output rrcb_pkg::pix_t      out_pixel,
  output logic                out_touched
);

  logic                  adv;
  rrcb_pkg::sqrt_side_t  sq_in_side;
  logic                  s_valid;
  rrcb_pkg::root_t       s_root;
  rrcb_pkg::sqrt_side_t  s_side;

  // coverage stage
  logic                  c_valid;
  logic                  c_live;
  rrcb_pkg::cov_t        c_cov;
  rrcb_pkg::pix_t        c_dest;
  // opacity stage
  logic                  e_valid;
  logic                  e_live;
  rrcb_pkg::chan_t       e_ea;
  rrcb_pkg::pix_t        e_dest;
  // blend product stage
  logic                  b_valid;
  logic                  b_live;
  rrcb_pkg::prod_t       b_num [rrcb_pkg::LANES];
  rrcb_pkg::pix_t        b_dest;

  rrcb_pkg::scov_t       cov_s;
  rrcb_pkg::cov_t        cov;
  logic                  cov_live;
  logic [rrcb_pkg::PROD_W:0] ea_sum;
  rrcb_pkg::chan_t       ea;
  rrcb_pkg::prod_t       num [rrcb_pkg::LANES];
  rrcb_pkg::pix_t        blend;

  // Back pipeline moves as one while the output register can take a request
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  assign sq_in_side.in_rect = q_head.in_rect;
  assign sq_in_side.corner  = q_head.corner;
  assign sq_in_side.dest    = q_head.dest;

  rrcb_isqrt u_isqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .in_valid   (!q_empty),
    .in_radicand({q_head.dist_sq, {rrcb_pkg::FRAC_W{1'b0}}}),
    .in_side    (sq_in_side),
    .out_valid  (s_valid),
    .out_root   (s_root),
    .out_side   (s_side)
  );

  // Coverage: radius minus distance in Q8, clamped to one
  always_comb begin
    cov_s = $signed({3'b000, cfg.corner_radius, 8'h00}) - $signed({1'b0, s_root});
    if (!s_side.corner) begin
      cov = rrcb_pkg::COV_ONE;
    end else if (cov_s > $signed(rrcb_pkg::scov_t'(rrcb_pkg::COV_ONE))) begin
      cov = rrcb_pkg::COV_ONE;
    end else begin
      cov = cov_s[rrcb_pkg::COV_W-1:0];
    end
    cov_live = s_side.in_rect && (!s_side.corner || (cov_s > 0));
  end

  // Effective opacity, rounded
  always_comb begin
    ea_sum = {{(rrcb_pkg::PROD_W + 1 - rrcb_pkg::CHAN_W){1'b0}}, cfg.fill_alpha}
           * {{(rrcb_pkg::PROD_W + 1 - rrcb_pkg::COV_W){1'b0}}, c_cov}
           + (rrcb_pkg::PROD_W + 1)'(128);
    ea     = ea_sum[rrcb_pkg::PROD_W-1:rrcb_pkg::CHAN_W];
  end

  // Per-lane products; alpha lane blends full scale over the old alpha
  always_comb begin
    rrcb_pkg::pix_t  src_word;
    rrcb_pkg::chan_t src;
    rrcb_pkg::chan_t dst;
    src_word = {rrcb_pkg::CHAN_MAX, cfg.fill_color};
    for (int i = 0; i < rrcb_pkg::LANES; i++) begin
      src    = src_word[rrcb_pkg::CHAN_W*i +: rrcb_pkg::CHAN_W];
      dst    = e_dest[rrcb_pkg::CHAN_W*i +: rrcb_pkg::CHAN_W];
      num[i] = rrcb_pkg::prod_t'(src) * rrcb_pkg::prod_t'(e_ea)
             + rrcb_pkg::prod_t'(dst) * rrcb_pkg::prod_t'(rrcb_pkg::CHAN_MAX - e_ea);
    end
  end

  // Divide by 255 with round-to-nearest
  always_comb begin
    rrcb_pkg::round_t t;
    rrcb_pkg::round_t rs;
    for (int i = 0; i < rrcb_pkg::LANES; i++) begin
      t  = rrcb_pkg::round_t'(b_num[i]) + rrcb_pkg::round_t'(128);
      rs = t + (t >> rrcb_pkg::CHAN_W);
      blend[rrcb_pkg::CHAN_W*i +: rrcb_pkg::CHAN_W] = rs[rrcb_pkg::PROD_W-1:rrcb_pkg::CHAN_W];
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      e_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      c_valid   <= s_valid;
      e_valid   <= c_valid;
      b_valid   <= e_valid;
      out_valid <= b_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      c_live      <= cov_live;
      c_cov       <= cov;
      c_dest      <= s_side.dest;
      e_live      <= c_live && (ea != '0);
      e_ea        <= ea;
      e_dest      <= c_dest;
      b_live      <= e_live;
      b_num       <= num;
      b_dest      <= e_dest;
      out_touched <= b_live;
      out_pixel   <= b_live ? blend : b_dest;
    end
  end

endmodule

@@ rtl/rounded_rect_coverage_blend.sv @@
// ---------------------------------------------------------------------------
// Antialiased rounded-rectangle blend
// Blends a straight-alpha fill over premultiplied ARGB pixels in a rect.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per request: x, y and the ARGB word. m_axis
//   returns one request per pixel, in order: the new ARGB word and a touched
//   flag in tuser. Registers are written through cfg_we/cfg_index/cfg_data,
//   one per cycle; the user must write them only while no pixel is in flight,
//   which the block itself does not enforce. Throughput: one pixel per cycle
//   while m_axis_tready is high, set by the 22-stage pipelined square root
//   and the blend multipliers, each of which takes a new pixel every cycle
//   while the back end is not held.
//   A three-stage front end classifies the pixel and squares its corner
//   distances, then writes a four-entry queue. The back end runs the root,
//   coverage, opacity and blend stages into the output register.
//   When m_axis_tready is low with m_axis_tvalid high the back end holds; the front keeps taking
//   pixels until the queue fills, then drops s_axis_tready.
//   Reset clears the configuration registers to zero and empties both pipelines and the queue.
// ---------------------------------------------------------------------------
`include "rounded_rect_coverage_blend_macros.svh"

module rounded_rect_coverage_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12], dest_pixel[55:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_pixel[31:0]
  output logic [0:0]  m_axis_tuser,   // was_touched[0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  rrcb_pkg::cfg_t    cfg;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  rrcb_pkg::q_item_t q_item;
  rrcb_pkg::q_item_t q_head;
  logic              touched;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (rrcb_pkg::cfg_reg_e'(cfg_index))
        rrcb_pkg::CFG_RECT_LEFT:     cfg.rect_left     <= cfg_data[11:0];
        rrcb_pkg::CFG_RECT_TOP:      cfg.rect_top      <= cfg_data[11:0];
        rrcb_pkg::CFG_RECT_WIDTH:    cfg.rect_width    <= cfg_data[12:0];
        rrcb_pkg::CFG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data[12:0];
        rrcb_pkg::CFG_CORNER_RADIUS: cfg.corner_radius <= cfg_data[11:0];
        rrcb_pkg::CFG_FILL_COLOR:    cfg.fill_color    <= cfg_data;
        rrcb_pkg::CFG_FILL_ALPHA:    cfg.fill_alpha    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rrcb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_x    (s_axis_tdata[11:0]),
    .in_y    (s_axis_tdata[23:12]),
    .in_dest (s_axis_tdata[55:24]),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  rrcb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(q_item),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rrcb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_head     (q_head),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_pixel  (m_axis_tdata),
    .out_touched(touched)
  );

  assign m_axis_tuser[0] = touched;

  // Checks
  `RRCB_ASSERT_IMP(a_push_not_full, clk, rst, q_push, !q_full)
  `RRCB_ASSERT_IMP(a_ready_low_only_full, clk, rst, !s_axis_tready, q_full)
  `RRCB_ASSERT_IMP(a_touch_needs_alpha, clk, rst, m_axis_tvalid && touched, cfg.fill_alpha != '0)
  `RRCB_ASSERT_IMP(a_empty_rect_untouched, clk, rst,
    m_axis_tvalid && ((cfg.rect_width == '0) || (cfg.rect_height == '0)), !touched)

endmodule
